// ===== rtl/csm_pkg.sv =====
// Shared types and constants for the character set membership search block.
`default_nettype none
package csm_pkg;

  localparam int IndexBits = 16;
  localparam int MaskWords = 4;
  localparam int QueueDepth = 2;

  localparam int ByteBits = 8;
  localparam int LimitBits = 16;
  localparam int MatchIndexBits = 16;
  localparam int MaskWordBits = 64;
  localparam int BucketCountBits = 3;
  localparam int CfgIndexBits = 3;

  localparam logic [CfgIndexBits-1:0] RegSetOffset = 3'd0;
  localparam logic [CfgIndexBits-1:0] RegBucketCount = 3'd1;
  localparam logic [CfgIndexBits-1:0] RegMaskWord0 = 3'd2;

  localparam int OpInvertBit = 0;
  localparam int OpLastBit = 1;

  typedef struct packed {
    logic                 has_byte;
    logic                 end_of_string;
    logic                 member;
    logic [1:0]           opcode;
    logic [LimitBits-1:0] limit_pos;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/char_set_membership_search.sv =====
// Top level of the character set membership search block.
//
//   Channel  Handshake                Payload
//   cfg      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in_valid_i/in_ready_o    data_byte_i, has_byte_i, end_of_string_i,
//                                     opcode_i, limit_pos_i
//   out      out_valid_o/out_ready_i  found_o, match_index_o, overflow_o
//
// One input beat is taken per cycle while the queue has room; the membership test
// sits in front of the queue, and a result is registered as its end-of-string beat
// leaves the queue. A two-entry queue separates the front from the back, so
// the input keeps flowing while a result waits in the output register.
// Reset clears the set registers and all string state; the block is ready at once.
`default_nettype none
module char_set_membership_search #(
  parameter int INDEX_BITS = csm_pkg::IndexBits,
  parameter int MASK_WORDS = csm_pkg::MaskWords
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [csm_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  wire logic [csm_pkg::MaskWordBits-1:0]    cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [csm_pkg::ByteBits-1:0]        data_byte_i,
  input  wire logic                                has_byte_i,
  input  wire logic                                end_of_string_i,
  input  wire logic [1:0]                          opcode_i,
  input  wire logic [csm_pkg::LimitBits-1:0]       limit_pos_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     found_o,
  output logic [csm_pkg::MatchIndexBits-1:0]       match_index_o,
  output logic                                     overflow_o
);

  logic push, push_ready, pop, pop_valid;
  csm_pkg::item_t push_item, pop_item;

  csm_front #(
    .MASK_WORDS(MASK_WORDS)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .data_byte_i(data_byte_i),
    .has_byte_i(has_byte_i),
    .end_of_string_i(end_of_string_i),
    .opcode_i(opcode_i),
    .limit_pos_i(limit_pos_i),
    .push_o(push),
    .push_item_o(push_item),
    .push_ready_i(push_ready)
  );

  csm_fifo #(
    .DEPTH(csm_pkg::QueueDepth)
  ) u_fifo (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .push_item_i(push_item),
    .push_ready_o(push_ready),
    .pop_i(pop),
    .pop_item_o(pop_item),
    .pop_valid_o(pop_valid)
  );

  csm_back #(
    .INDEX_BITS(INDEX_BITS)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .item_i(pop_item),
    .item_valid_i(pop_valid),
    .pop_o(pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .found_o(found_o),
    .match_index_o(match_index_o),
    .overflow_o(overflow_o)
  );

endmodule
`default_nettype wire

// ===== rtl/csm_fifo.sv =====
// Short queue of classified items between the front and back parts.
`default_nettype none
module csm_fifo #(
  parameter int DEPTH = csm_pkg::QueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  csm_pkg::item_t      push_item_i,
  output logic                push_ready_o,
  input  wire logic           pop_i,
  output csm_pkg::item_t      pop_item_o,
  output logic                pop_valid_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CountBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
  localparam logic [CountBits-1:0] FullCount = CountBits'(DEPTH);

  csm_pkg::item_t store_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CountBits-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign push_ready_o = (count_q != FullCount);
  assign pop_valid_o = (count_q != '0);
  assign pop_item_o = store_q[rd_ptr_q];
  assign do_push = push_i && push_ready_o;
  assign do_pop = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("Queue count exceeds its depth.");
`endif

endmodule
`default_nettype wire

// ===== rtl/csm_front.sv =====
// Front part: holds the set registers, accepts beats and tests set membership.
`default_nettype none
module csm_front #(
  parameter int MASK_WORDS = csm_pkg::MaskWords
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [csm_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  wire logic [csm_pkg::MaskWordBits-1:0]    cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [csm_pkg::ByteBits-1:0]        data_byte_i,
  input  wire logic                                has_byte_i,
  input  wire logic                                end_of_string_i,
  input  wire logic [1:0]                          opcode_i,
  input  wire logic [csm_pkg::LimitBits-1:0]       limit_pos_i,
  output logic                                     push_o,
  output csm_pkg::item_t                           push_item_o,
  input  wire logic                                push_ready_i
);

  localparam logic [csm_pkg::BucketCountBits-1:0] MaxBuckets =
    csm_pkg::BucketCountBits'(MASK_WORDS);

  logic [csm_pkg::ByteBits-1:0] set_offset_q;
  logic [csm_pkg::BucketCountBits-1:0] bucket_count_q;
  logic [csm_pkg::MaskWordBits-1:0] mask_q [MASK_WORDS];

  logic cfg_we;
  logic [csm_pkg::BucketCountBits-1:0] used_buckets;
  logic [csm_pkg::ByteBits-1:0] rel;
  logic [1:0] bucket;
  logic [csm_pkg::MaskWordBits-1:0] sel_word;
  logic member;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_offset_q <= '0;
      bucket_count_q <= '0;
      for (int w = 0; w < MASK_WORDS; w++) begin
        mask_q[w] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index_i == csm_pkg::RegSetOffset) begin
        set_offset_q <= cfg_data_i[csm_pkg::ByteBits-1:0];
      end
      if (cfg_index_i == csm_pkg::RegBucketCount) begin
        bucket_count_q <= cfg_data_i[csm_pkg::BucketCountBits-1:0];
      end
      for (int w = 0; w < MASK_WORDS; w++) begin
        if (cfg_index_i == csm_pkg::RegMaskWord0 + csm_pkg::CfgIndexBits'(w)) begin
          mask_q[w] <= cfg_data_i;
        end
      end
    end
  end

  assign used_buckets = (bucket_count_q > MaxBuckets) ? MaxBuckets : bucket_count_q;
  assign rel = data_byte_i - set_offset_q;
  assign bucket = rel[7:6];

  always_comb begin
    sel_word = '0;
    for (int w = 0; w < MASK_WORDS; w++) begin
      if (bucket == 2'(w)) begin
        sel_word = mask_q[w];
      end
    end
  end

  assign member = (data_byte_i >= set_offset_q)
               && ({1'b0, bucket} < used_buckets)
               && sel_word[rel[5:0]];

  assign in_ready_o = push_ready_i;
  assign push_o = in_valid_i && push_ready_i;

  always_comb begin
    push_item_o.has_byte = has_byte_i;
    push_item_o.end_of_string = end_of_string_i;
    push_item_o.member = member;
    push_item_o.opcode = opcode_i;
    push_item_o.limit_pos = limit_pos_i;
  end

endmodule
`default_nettype wire

// ===== rtl/csm_back.sv =====
// Back part: tracks the string position and the kept hit, and registers the result.
`default_nettype none
module csm_back #(
  parameter int INDEX_BITS = csm_pkg::IndexBits
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  csm_pkg::item_t                            item_i,
  input  wire logic                                 item_valid_i,
  output logic                                      pop_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      found_o,
  output logic [csm_pkg::MatchIndexBits-1:0]        match_index_o,
  output logic                                      overflow_o
);

  localparam logic [INDEX_BITS-1:0] PosMax = '1;

  logic [INDEX_BITS-1:0] pos_q, pos_d, lim_q, lim_d, hit_pos_q, hit_pos_d;
  logic [1:0] mode_q, mode_d;
  logic in_str_q, in_str_d, hit_q, hit_d, sat_q, sat_d;
  logic out_valid_q, out_valid_d;
  logic found_q;
  logic [csm_pkg::MatchIndexBits-1:0] match_index_q;
  logic overflow_q;
  logic start, match;

  assign pop_o = item_valid_i && (!item_i.end_of_string || !out_valid_q || out_ready_i);
  assign start = !in_str_q;

  always_comb begin
    mode_d = start ? item_i.opcode : mode_q;
    lim_d = start ? INDEX_BITS'(item_i.limit_pos) : lim_q;
    pos_d = start ? '0 : pos_q;
    hit_d = start ? 1'b0 : hit_q;
    hit_pos_d = start ? '0 : hit_pos_q;
    sat_d = start ? 1'b0 : sat_q;
    match = item_i.member ^ mode_d[csm_pkg::OpInvertBit];
    if (item_i.has_byte && !sat_d) begin
      if (!mode_d[csm_pkg::OpLastBit]) begin
        if (match && !hit_d && pos_d >= lim_d) begin
          hit_d = 1'b1;
          hit_pos_d = pos_d;
        end
      end else if (match && pos_d <= lim_d) begin
        hit_d = 1'b1;
        hit_pos_d = pos_d;
      end
      if (pos_d == PosMax) begin
        sat_d = 1'b1;
      end else begin
        pos_d = pos_d + 1'b1;
      end
    end
    in_str_d = !item_i.end_of_string;
    out_valid_d = out_valid_q && !out_ready_i;
    if (item_i.end_of_string) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      lim_q <= '0;
      hit_pos_q <= '0;
      mode_q <= '0;
      in_str_q <= 1'b0;
      hit_q <= 1'b0;
      sat_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      pos_q <= pos_d;
      lim_q <= lim_d;
      hit_pos_q <= hit_pos_d;
      mode_q <= mode_d;
      in_str_q <= in_str_d;
      hit_q <= hit_d;
      sat_q <= sat_d;
      out_valid_q <= out_valid_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.end_of_string) begin
      found_q <= hit_d;
      match_index_q <= hit_d ? csm_pkg::MatchIndexBits'(hit_pos_d) : '0;
      overflow_q <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o = found_q;
  assign match_index_o = match_index_q;
  assign overflow_o = overflow_q;

`ifndef NO_ASSERTIONS
  a_sat_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> pos_q == PosMax)
    else $error("Saturation flag set while the position counter is not at its maximum.");

  a_hit_behind_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> hit_pos_q <= pos_q)
    else $error("Kept hit lies beyond the current position.");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.end_of_string |=> out_valid_q)
    else $error("End of string did not load a result.");
`endif

endmodule
`default_nettype wire
